FILE: hw/rtl/lsb_text_embedder_defines.svh
// ----------------------------------------------------------------------------
// lsb_text_embedder_defines.svh
// Assertion macros shared by the text embedder RTL
// ----------------------------------------------------------------------------
`ifndef LSB_TEXT_EMBEDDER_DEFINES_SVH
`define LSB_TEXT_EMBEDDER_DEFINES_SVH

`ifndef SYNTHESIS

// property that must hold at every clock edge out of reset
`define LTE_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("lte assertion failed");

// implication checked at the same edge
`define LTE_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("lte implication failed");

`else

`define LTE_ASSERT(label, prop)
`define LTE_ASSERT_IMPL(label, ante, cons)

`endif

`endif

FILE: hw/rtl/lte_pkg.sv
// ----------------------------------------------------------------------------
// lte_pkg
// Types and constants of the text embedder
// ----------------------------------------------------------------------------
package lte_pkg;

    // input commands
    typedef enum logic [1:0] {
        CMD_BYTE    = 2'd0,
        CMD_END     = 2'd1,
        CMD_SAMPLE  = 2'd2,
        CMD_RESTART = 2'd3
    } t_cmd;

    // message phases of the back end
    typedef enum logic [2:0] {
        PH_FIRST = 3'd0,
        PH_EMBED = 3'd1,
        PH_NEXT  = 3'd2,
        PH_TAIL  = 3'd3,
        PH_DONE  = 3'd4
    } t_phase;

    // register indexes (byte address / 4)
    localparam logic [1:0] REG_BITS_CODE    = 2'd0;
    localparam logic [1:0] REG_SAMPLE_BYTES = 2'd1;
    localparam logic [1:0] REG_SAMPLE_LIMIT = 2'd2;

    // bits per sample codes
    localparam logic [1:0] BITS_ONE = 2'd0;
    localparam logic [1:0] BITS_TWO = 2'd1;

    // characters
    localparam logic [7:0] CHAR_NEWLINE = 8'h0a;
    localparam logic [7:0] CHAR_COLON   = 8'h3a;
    localparam logic [7:0] CHAR_PAREN   = 8'h29;

    // chunk masks
    localparam logic [3:0] CMASK_ONE  = 4'h1;
    localparam logic [3:0] CMASK_TWO  = 4'h3;
    localparam logic [3:0] CMASK_FOUR = 4'hf;

    localparam logic [1:0] SMILE_MAX = 2'd3;
    localparam logic [1:0] TAIL_LAST = 2'd2;

    // queued item
    typedef struct packed {
        t_cmd        cmd;
        logic [31:0] data;
    } t_item;

    // register values seen by the back end
    typedef struct packed {
        logic [1:0]  bits_code;
        logic [31:0] sample_limit;
    } t_cfg;

    // tail characters in order
    function automatic logic [7:0] tail_char(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = CHAR_NEWLINE;
            2'd1:    c = CHAR_COLON;
            default: c = CHAR_PAREN;
        endcase
        return c;
    endfunction

endpackage

FILE: hw/rtl/lte_in_if.sv
// ----------------------------------------------------------------------------
// lte_in_if
// Input channel: command and data word with valid/ready
// ----------------------------------------------------------------------------
interface lte_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [31:0] data_value;

    modport source (output valid, output command, output data_value, input ready);
    modport sink   (input valid, input command, input data_value, output ready);
endinterface

FILE: hw/rtl/lte_out_if.sv
// ----------------------------------------------------------------------------
// lte_out_if
// Output channel: processed audio sample with valid/ready
// ----------------------------------------------------------------------------
interface lte_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] sample_out;
    logic        carries_message;
    logic        underrun;
    logic [31:0] chars_written;

    modport source (
        output valid, output sample_out, output carries_message,
        output underrun, output chars_written, input ready
    );
    modport sink (
        input valid, input sample_out, input carries_message,
        input underrun, input chars_written, output ready
    );
endinterface

FILE: hw/rtl/lte_front.sv
// ----------------------------------------------------------------------------
// lte_front
// Accepts input transfers, decodes the command and masks the data word
// ----------------------------------------------------------------------------
module lte_front (
    lte_in_if.sink         i_in,
    input  logic [2:0]     i_sample_bytes,
    input  logic           i_q_full,
    output logic           o_push,
    output lte_pkg::t_item o_item
);
    import lte_pkg::*;

    logic [31:0] w_wmask;

    // sample width mask, zero acts as one byte, above four as four
    always_comb begin
        case (i_sample_bytes)
            3'd0, 3'd1: w_wmask = 32'h0000_00ff;
            3'd2:       w_wmask = 32'h0000_ffff;
            3'd3:       w_wmask = 32'h00ff_ffff;
            default:    w_wmask = 32'hffff_ffff;
        endcase
    end

    // accept whenever the queue has room
    assign i_in.ready = !i_q_full;
    assign o_push     = i_in.valid && !i_q_full;

    // classify the transfer
    assign o_item.cmd  = t_cmd'(i_in.command);
    assign o_item.data = i_in.data_value & w_wmask;

endmodule

FILE: hw/rtl/lte_queue.sv
// ----------------------------------------------------------------------------
// lte_queue
// Short register queue between front and back end
// ----------------------------------------------------------------------------
module lte_queue #(
    parameter int DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  lte_pkg::t_item i_item,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output lte_pkg::t_item o_item
);
    import lte_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item              r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [PTR_W-1:0]   n_wr_ptr;
    logic [PTR_W-1:0]   n_rd_ptr;
    logic [CNT_W-1:0]   n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    // pointer and count update with wrap at the depth
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

FILE: hw/rtl/lte_back.sv
// ----------------------------------------------------------------------------
// lte_back
// Message state machine, chunk embedding and output register
// ----------------------------------------------------------------------------
module lte_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  lte_pkg::t_cfg  i_cfg,
    input  logic           i_q_valid,
    input  lte_pkg::t_item i_q_item,
    output logic           o_pop,
    lte_out_if.source      o_out
);
    import lte_pkg::*;

    // message state
    t_phase      r_phase;
    t_phase      n_phase;
    logic [7:0]  r_char;
    logic [7:0]  n_char;
    logic [2:0]  r_chunk;
    logic [2:0]  n_chunk;
    logic [1:0]  r_tail;
    logic [1:0]  n_tail;
    logic [1:0]  r_smile;
    logic [1:0]  n_smile;
    logic        r_ovf;
    logic        n_ovf;
    logic [31:0] r_sample_cnt;
    logic [31:0] n_sample_cnt;
    logic [31:0] r_char_cnt;
    logic [31:0] n_char_cnt;

    // output register
    logic        r_out_valid;
    logic        n_out_valid;
    logic [31:0] r_out_sample;
    logic [31:0] n_out_sample;
    logic        r_out_carries;
    logic        n_out_carries;
    logic        r_out_under;
    logic        n_out_under;
    logic [31:0] r_out_chars;
    logic [31:0] n_out_chars;

    // per item decode
    logic        w_out_free;
    logic [2:0]  w_last;
    logic [3:0]  w_cmask;
    logic [3:0]  w_chunks;
    logic [2:0]  w_idx;
    logic [2:0]  w_shift;
    logic [7:0]  w_shifted;
    logic [3:0]  w_bits;
    logic        w_smile_chr;
    logic [1:0]  w_smile_inc;
    logic        w_cnt_sat;
    logic [3:0]  w_room_add;
    logic [32:0] w_room;

    assign w_out_free = !r_out_valid || o_out.ready;
    assign o_pop      = i_q_valid && ((i_q_item.cmd != CMD_SAMPLE) || w_out_free);

    // chunk geometry for the bits setting
    always_comb begin
        unique case (i_cfg.bits_code)
            BITS_ONE: begin
                w_last   = 3'd7;
                w_cmask  = CMASK_ONE;
                w_chunks = 4'd8;
            end
            BITS_TWO: begin
                w_last   = 3'd3;
                w_cmask  = CMASK_TWO;
                w_chunks = 4'd4;
            end
            default: begin
                w_last   = 3'd1;
                w_cmask  = CMASK_FOUR;
                w_chunks = 4'd2;
            end
        endcase
    end

    // chunk select, index held at the last chunk of the setting
    assign w_idx = (r_chunk > w_last) ? w_last : r_chunk;

    always_comb begin
        unique case (i_cfg.bits_code)
            BITS_ONE: w_shift = 3'd7 - w_idx;
            BITS_TWO: w_shift = 3'd6 - {w_idx[1:0], 1'b0};
            default:  w_shift = {~w_idx[0], 2'b00};
        endcase
    end

    assign w_shifted = r_char >> w_shift;
    assign w_bits    = w_shifted[3:0] & w_cmask;

    // smiley count bump for a later byte
    assign w_smile_chr = (i_q_item.data[7:0] == CHAR_COLON) ||
                         (i_q_item.data[7:0] == CHAR_PAREN);
    assign w_smile_inc = (w_smile_chr && (r_smile != SMILE_MAX)) ?
                         r_smile + 2'd1 : r_smile;

    // room check against the sample limit, on the updated count
    assign w_cnt_sat  = (r_sample_cnt == 32'hffff_ffff);
    assign w_room_add = w_chunks + {3'b000, !w_cnt_sat};
    assign w_room     = {1'b0, r_sample_cnt} + {29'd0, w_room_add};

    // next state and output
    always_comb begin
        n_phase       = r_phase;
        n_char        = r_char;
        n_chunk       = r_chunk;
        n_tail        = r_tail;
        n_smile       = r_smile;
        n_ovf         = r_ovf;
        n_sample_cnt  = r_sample_cnt;
        n_char_cnt    = r_char_cnt;
        n_out_valid   = r_out_valid && !o_out.ready;
        n_out_sample  = r_out_sample;
        n_out_carries = r_out_carries;
        n_out_under   = r_out_under;
        n_out_chars   = r_out_chars;

        if (o_pop) begin
            unique case (i_q_item.cmd)
                CMD_RESTART: begin
                    n_phase      = PH_FIRST;
                    n_char       = '0;
                    n_chunk      = '0;
                    n_tail       = '0;
                    n_smile      = '0;
                    n_ovf        = 1'b0;
                    n_sample_cnt = '0;
                    n_char_cnt   = '0;
                end
                CMD_BYTE: begin
                    if (r_phase == PH_FIRST) begin
                        n_char  = i_q_item.data[7:0];
                        n_chunk = '0;
                        n_phase = PH_EMBED;
                    end else if (r_phase == PH_NEXT) begin
                        n_smile = w_smile_inc;
                        if ((w_smile_inc == SMILE_MAX) || r_ovf) begin
                            if (w_smile_inc != TAIL_LAST) begin
                                n_phase = PH_TAIL;
                                n_tail  = '0;
                                n_char  = CHAR_NEWLINE;
                                n_chunk = '0;
                            end else begin
                                n_phase = PH_DONE;
                            end
                        end else begin
                            n_char  = i_q_item.data[7:0];
                            n_chunk = '0;
                            n_phase = PH_EMBED;
                        end
                    end
                end
                CMD_END: begin
                    if ((r_phase == PH_FIRST) || (r_phase == PH_NEXT)) begin
                        if (r_smile != TAIL_LAST) begin
                            n_phase = PH_TAIL;
                            n_tail  = '0;
                            n_char  = CHAR_NEWLINE;
                            n_chunk = '0;
                        end else begin
                            n_phase = PH_DONE;
                        end
                    end
                end
                default: begin
                    // audio sample, one result each
                    n_sample_cnt  = w_cnt_sat ? r_sample_cnt : r_sample_cnt + 32'd1;
                    n_out_valid   = 1'b1;
                    n_out_sample  = i_q_item.data;
                    n_out_carries = 1'b0;
                    n_out_under   = 1'b0;
                    if ((r_phase == PH_FIRST) || (r_phase == PH_NEXT)) begin
                        n_out_under = 1'b1;
                    end else if ((r_phase == PH_EMBED) || (r_phase == PH_TAIL)) begin
                        n_out_sample  = (i_q_item.data & ~{28'd0, w_cmask}) |
                                        {28'd0, w_bits};
                        n_out_carries = 1'b1;
                        if (w_idx == w_last) begin
                            if (r_char_cnt != 32'hffff_ffff) begin
                                n_char_cnt = r_char_cnt + 32'd1;
                            end
                            n_chunk = '0;
                            if (r_phase == PH_EMBED) begin
                                n_ovf   = (w_room >= {1'b0, i_cfg.sample_limit});
                                n_phase = PH_NEXT;
                            end else if (r_tail == TAIL_LAST) begin
                                n_tail  = '0;
                                n_phase = PH_DONE;
                            end else begin
                                n_tail = r_tail + 2'd1;
                                n_char = tail_char(r_tail + 2'd1);
                            end
                        end else begin
                            n_chunk = w_idx + 3'd1;
                        end
                    end
                    // character count as of this sample
                    n_out_chars = n_char_cnt;
                end
            endcase
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_FIRST;
            r_char       <= '0;
            r_chunk      <= '0;
            r_tail       <= '0;
            r_smile      <= '0;
            r_ovf        <= 1'b0;
            r_sample_cnt <= '0;
            r_char_cnt   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_char       <= n_char;
            r_chunk      <= n_chunk;
            r_tail       <= n_tail;
            r_smile      <= n_smile;
            r_ovf        <= n_ovf;
            r_sample_cnt <= n_sample_cnt;
            r_char_cnt   <= n_char_cnt;
            r_out_valid  <= n_out_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_out_sample  <= n_out_sample;
        r_out_carries <= n_out_carries;
        r_out_under   <= n_out_under;
        r_out_chars   <= n_out_chars;
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.sample_out      = r_out_sample;
    assign o_out.carries_message = r_out_carries;
    assign o_out.underrun        = r_out_under;
    assign o_out.chars_written   = r_out_chars;

endmodule

FILE: hw/rtl/lsb_text_embedder.sv
// ----------------------------------------------------------------------------
// lsb_text_embedder
// Hides message bytes in the low bits of an audio sample stream
// ----------------------------------------------------------------------------
// One input transfer is taken per clock while the queue has room: message
// bytes, end and restart commands and audio samples all enter a short queue
// and the back end retires one item per cycle, a sample once the output slot
// is free, so the sustained rate is one item per clock without output stalls,
// set by the single state update of the message state machine. Each audio
// sample gives one registered output transfer; other commands give none. The
// output register lets new input flow into the queue while a result waits.
// Registers (APB, byte address 4*i): bits_code at 0, sample_bytes at 4,
// sample_limit at 8; write them only while the block is idle.
`include "lsb_text_embedder_defines.svh"

module lsb_text_embedder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lte_in_if.sink      i_in,
    lte_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lte_pkg::*;

    logic [1:0]  r_bits_code;
    logic [2:0]  r_sample_bytes;
    logic [31:0] r_sample_limit;

    logic        w_push;
    logic        w_pop;
    logic        w_q_full;
    logic        w_q_valid;
    t_item       w_push_item;
    t_item       w_head;
    t_cfg        w_cfg;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits_code    <= 2'd0;
            r_sample_bytes <= 3'd2;
            r_sample_limit <= 32'd0;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                REG_BITS_CODE:    r_bits_code    <= pwdata[1:0];
                REG_SAMPLE_BYTES: r_sample_bytes <= pwdata[2:0];
                REG_SAMPLE_LIMIT: r_sample_limit <= pwdata;
                default: ;
            endcase
        end
    end

    // configuration reads
    always_comb begin
        unique case (paddr[3:2])
            REG_BITS_CODE:    prdata = {30'd0, r_bits_code};
            REG_SAMPLE_BYTES: prdata = {29'd0, r_sample_bytes};
            REG_SAMPLE_LIMIT: prdata = r_sample_limit;
            default:          prdata = 32'd0;
        endcase
    end

    assign pready = 1'b1;

    assign w_cfg.bits_code    = r_bits_code;
    assign w_cfg.sample_limit = r_sample_limit;

    // front end
    lte_front u_front (
        .i_in           (i_in),
        .i_sample_bytes (r_sample_bytes),
        .i_q_full       (w_q_full),
        .o_push         (w_push),
        .o_item         (w_push_item)
    );

    // queue between front and back
    lte_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .i_pop   (w_pop),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_item  (w_head)
    );

    // back end
    lte_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_q_valid (w_q_valid),
        .i_q_item  (w_head),
        .o_pop     (w_pop),
        .o_out     (o_out)
    );

    // a sample leaves the queue only when the output slot is free
    `LTE_ASSERT_IMPL(a_sample_slot_free, w_pop && (w_head.cmd == CMD_SAMPLE),
        !o_out.valid || o_out.ready)
    // a sample is either embedded or an underrun, never both
    `LTE_ASSERT(a_carry_xor_under, !(o_out.valid && o_out.carries_message && o_out.underrun))
    // one byte samples carry no bits above the low byte
    `LTE_ASSERT_IMPL(a_byte_width_mask, o_out.valid && (r_sample_bytes == 3'd1),
        o_out.sample_out[31:8] == 24'd0)

endmodule

FILE: tb/lte_embed_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lte_embed_checker
// Watches item, sample and register transfers of the text embedder, predicts
// every output sample and compares it field by field with what comes out
// ----------------------------------------------------------------------------
module lte_embed_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lte_in_if           i_in,
    lte_out_if          i_out,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic        i_pready,
    input  logic [3:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output int          o_fail_count,
    output int          o_pending
);
    import lte_pkg::*;

    // exactly this many smileys means the message needs no tail
    localparam logic [1:0] SMILE_QUIET = 2'd2;

    typedef struct packed {
        logic [31:0] sample_out;
        logic        carries_message;
        logic        underrun;
        logic [31:0] chars_written;
    } t_stego_sample;

    t_stego_sample expected_samples[$];
    t_stego_sample want;

    // register copies
    logic [1:0]  cfg_bits_code;
    logic [2:0]  cfg_sample_bytes;
    logic [31:0] cfg_sample_limit;

    // message state
    logic [7:0]  cur_char;
    logic [2:0]  chunk_idx;
    t_phase      msg_phase;
    logic [1:0]  tail_idx;
    logic [1:0]  smile_cnt;
    logic        room_short;
    logic [31:0] samples_seen;
    logic [31:0] chars_done;

    function automatic logic [7:0] tail_at(input logic [1:0] idx);
        case (idx)
            2'd0:    return CHAR_NEWLINE;
            2'd1:    return CHAR_COLON;
            default: return CHAR_PAREN;
        endcase
    endfunction

    task automatic clear_message();
        cur_char     = '0;
        chunk_idx    = '0;
        msg_phase    = PH_FIRST;
        tail_idx     = '0;
        smile_cnt    = '0;
        room_short   = 1'b0;
        samples_seen = '0;
        chars_done   = '0;
    endtask

    // message over: tail unless exactly two smileys were seen
    task automatic close_message();
        if (smile_cnt != SMILE_QUIET) begin
            msg_phase = PH_TAIL;
            tail_idx  = '0;
            cur_char  = tail_at(2'd0);
            chunk_idx = '0;
        end else begin
            msg_phase = PH_DONE;
        end
    endtask

    // advance the message state by one accepted item
    task automatic step_embedder(input t_cmd cmd, input logic [31:0] data);
        int unsigned    nbits;
        int unsigned    nchunks;
        int unsigned    idx;
        longint unsigned room;
        logic [31:0]    wmask;
        logic [31:0]    cmask;
        logic [31:0]    chunk;
        t_stego_sample  res;
        nbits = (cfg_bits_code == BITS_ONE) ? 1 : (cfg_bits_code == BITS_TWO) ? 2 : 4;
        nchunks = 8 / nbits;
        cmask = (32'd1 << nbits) - 32'd1;
        case (cfg_sample_bytes)
            3'd0, 3'd1: wmask = 32'h0000_00ff;
            3'd2:       wmask = 32'h0000_ffff;
            3'd3:       wmask = 32'h00ff_ffff;
            default:    wmask = 32'hffff_ffff;
        endcase
        case (cmd)
            CMD_RESTART: begin
                clear_message();
            end
            CMD_BYTE: begin
                if (msg_phase == PH_FIRST) begin
                    cur_char  = data[7:0];
                    chunk_idx = '0;
                    msg_phase = PH_EMBED;
                end else if (msg_phase == PH_NEXT) begin
                    if ((data[7:0] == CHAR_COLON || data[7:0] == CHAR_PAREN) &&
                        smile_cnt < SMILE_MAX)
                        smile_cnt = smile_cnt + 2'd1;
                    if (smile_cnt == SMILE_MAX || room_short) begin
                        close_message();
                    end else begin
                        cur_char  = data[7:0];
                        chunk_idx = '0;
                        msg_phase = PH_EMBED;
                    end
                end
            end
            CMD_END: begin
                if (msg_phase == PH_FIRST || msg_phase == PH_NEXT)
                    close_message();
            end
            default: begin
                if (samples_seen != 32'hffff_ffff)
                    samples_seen = samples_seen + 32'd1;
                res.sample_out      = data & wmask;
                res.carries_message = 1'b0;
                res.underrun        = 1'b0;
                if (msg_phase == PH_FIRST || msg_phase == PH_NEXT) begin
                    res.underrun = 1'b1;
                end else if (msg_phase == PH_EMBED || msg_phase == PH_TAIL) begin
                    idx = chunk_idx;
                    // bits code changed mid character: hold at the last chunk
                    if (idx >= nchunks)
                        idx = nchunks - 1;
                    chunk = ({24'd0, cur_char} >> (8 - nbits * (idx + 1))) & cmask;
                    res.sample_out      = ((data & ~cmask) | chunk) & wmask;
                    res.carries_message = 1'b1;
                    if (idx + 1 >= nchunks) begin
                        if (chars_done != 32'hffff_ffff)
                            chars_done = chars_done + 32'd1;
                        chunk_idx = '0;
                        if (msg_phase == PH_EMBED) begin
                            room = samples_seen;
                            room = room + nchunks;
                            room_short = (room >= cfg_sample_limit);
                            msg_phase  = PH_NEXT;
                        end else if (tail_idx == TAIL_LAST) begin
                            tail_idx  = '0;
                            msg_phase = PH_DONE;
                        end else begin
                            tail_idx = tail_idx + 2'd1;
                            cur_char = tail_at(tail_idx);
                        end
                    end else begin
                        chunk_idx = 3'(idx + 1);
                    end
                end
                res.chars_written = chars_done;
                expected_samples.push_back(res);
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
        if (got_v !== exp_v) begin
            $error("%s: expected %h, got %h", name, exp_v, got_v);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_bits_code    = BITS_ONE;
            cfg_sample_bytes = 3'd2;
            cfg_sample_limit = '0;
            clear_message();
            expected_samples.delete();
            o_fail_count = 0;
        end else begin
            // register writes
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[3:2])
                    REG_BITS_CODE:    cfg_bits_code    = i_pwdata[1:0];
                    REG_SAMPLE_BYTES: cfg_sample_bytes = i_pwdata[2:0];
                    REG_SAMPLE_LIMIT: cfg_sample_limit = i_pwdata;
                    default: ;
                endcase
            end
            // output transfer against the oldest prediction
            if (i_out.valid && i_out.ready) begin
                if (expected_samples.size() == 0) begin
                    $error("output transfer with no sample expected");
                    o_fail_count++;
                end else begin
                    want = expected_samples.pop_front();
                    check_field("sample_out", want.sample_out, i_out.sample_out);
                    check_field("carries_message", {31'd0, want.carries_message},
                                {31'd0, i_out.carries_message});
                    check_field("underrun", {31'd0, want.underrun},
                                {31'd0, i_out.underrun});
                    check_field("chars_written", want.chars_written,
                                i_out.chars_written);
                end
            end
            // input transfer
            if (i_in.valid && i_in.ready)
                step_embedder(t_cmd'(i_in.command), i_in.data_value);
        end
        o_pending = expected_samples.size();
    end

endmodule

FILE: tb/tb_lsb_text_embedder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lsb_text_embedder
// Drives message bytes, end and restart commands and audio samples into the
// text embedder under several register settings with random gaps and
// stalls; a checker beside the block predicts and compares every sample
// ----------------------------------------------------------------------------
module tb_lsb_text_embedder;
    import lte_pkg::*;

    localparam int HALF_PERIOD    = 4;
    localparam int RESET_CYCLES   = 5;
    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ITEMS_PER_SET  = 250;

    localparam logic [1:0] BITS_FOUR  = 2'd2;
    localparam logic [1:0] BITS_SPARE = 2'd3;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          tx_idle_pct;
    int          rx_idle_pct;
    logic        hold_request;
    logic        hold_served;
    int          stall_cycles = 0;
    int          fail_count;
    int          pending;
    logic [1:0]  bits_now;

    lte_in_if  in_ch();
    lte_out_if out_ch();

    lsb_text_embedder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    lte_embed_checker u_monitor (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // one item, with random gaps before it; valid stays up after the transfer
    task automatic send_item(input t_cmd cmd, input logic [31:0] data);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.command    <= cmd;
        in_ch.data_value <= data;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
    endtask

    // stop sending, wait for every sample, then let queued commands retire
    task automatic drain();
        in_ch.valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [3:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
    endtask

    task automatic write_config(input logic [1:0] bits, input logic [2:0] nbytes,
                                input logic [31:0] limit);
        apb_write({REG_BITS_CODE, 2'b00}, {30'd0, bits});
        apb_write({REG_SAMPLE_BYTES, 2'b00}, {29'd0, nbytes});
        apb_write({REG_SAMPLE_LIMIT, 2'b00}, limit);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        bits_now = bits;
    endtask

    // mostly well-formed messages with random content, some noise
    task automatic send_messages(input int quota);
        int         sent;
        int         nchunks;
        int         nchars;
        int         nsamp;
        int         roll;
        int         c;
        bit         resume;
        logic [31:0] word;
        sent    = 0;
        resume  = 1'b1;
        nchunks = (bits_now == BITS_ONE) ? 8 : (bits_now == BITS_TWO) ? 4 : 2;
        while (sent < quota) begin
            if ($urandom_range(99) < 85) begin
                // the first message carries on from the state left by the last set
                if (!resume) begin
                    send_item(CMD_RESTART, $urandom);
                    sent++;
                end
                resume = 1'b0;
                nchars = $urandom_range(12, 1);
                for (c = 0; c < nchars; c++) begin
                    roll = $urandom_range(99);
                    word = $urandom;
                    if (roll < 10)
                        word[7:0] = CHAR_COLON;
                    else if (roll < 18)
                        word[7:0] = CHAR_PAREN;
                    else if (roll < 22)
                        word[7:0] = CHAR_NEWLINE;
                    send_item(CMD_BYTE, word);
                    // occasional extra or missing sample, or a stray end
                    roll  = $urandom_range(49);
                    nsamp = nchunks + ((roll == 0) ? 1 : 0) - ((roll == 1) ? 1 : 0);
                    repeat (nsamp) send_item(CMD_SAMPLE, $urandom);
                    if (roll == 2)
                        send_item(CMD_END, $urandom);
                    sent += nsamp + 1;
                end
                if ($urandom_range(9) != 0)
                    send_item(CMD_END, $urandom);
                nsamp = 3 * nchunks + $urandom_range(3);
                repeat (nsamp) send_item(CMD_SAMPLE, $urandom);
                sent += nsamp + 1;
            end else begin
                repeat ($urandom_range(10, 1))
                    send_item(t_cmd'($urandom_range(3)), $urandom);
            end
        end
        // leave a character half embedded for the next setting
        send_item(CMD_RESTART, $urandom);
        send_item(CMD_BYTE, $urandom);
        send_item(CMD_SAMPLE, $urandom);
    endtask

    task automatic run_setting(input logic [1:0] bits, input logic [2:0] nbytes,
                               input logic [31:0] limit, input int tx_pct,
                               input int rx_pct);
        write_config(bits, nbytes, limit);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        send_messages(ITEMS_PER_SET);
        drain();
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        out_ch.ready <= 1'b0;
        hold_served = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request && !hold_served) begin
                hold_served = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            psel)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("lsb_text_embedder test failed");
            $finish;
        end
    end

    initial begin
        in_ch.valid      <= 1'b0;
        in_ch.command    <= CMD_BYTE;
        in_ch.data_value <= '0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        i_rst_n          <= 1'b0;
        tx_idle_pct  = 33;
        rx_idle_pct  = 80;
        hold_request = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: four bits per sample, full width samples, no room limit
        write_config(BITS_FOUR, 3'd4, 32'hffff_ffff);
        send_item(CMD_RESTART, 32'h0);
        send_item(CMD_SAMPLE, 32'hffff_ffff);      // sample before any byte
        send_item(CMD_BYTE, 32'hffff_ffff);        // first byte taken unchecked
        send_item(CMD_BYTE, 32'h0000_0000);        // byte while embedding
        send_item(CMD_END, 32'h0);                 // end while embedding
        send_item(CMD_SAMPLE, 32'h0000_0000);
        send_item(CMD_SAMPLE, 32'hffff_ffff);
        send_item(CMD_BYTE, {24'h0, CHAR_COLON});
        send_item(CMD_SAMPLE, 32'haaaa_aaaa);
        send_item(CMD_SAMPLE, 32'h5555_5555);
        send_item(CMD_BYTE, {24'hffffff, CHAR_PAREN});
        send_item(CMD_SAMPLE, 32'h0000_0000);
        send_item(CMD_SAMPLE, 32'hffff_ffff);
        send_item(CMD_BYTE, {24'h0, CHAR_COLON});  // third smiley ends the message
        send_item(CMD_BYTE, 32'h0000_0041);        // byte during the tail
        repeat (3) begin
            send_item(CMD_SAMPLE, 32'h0000_0000);
            send_item(CMD_SAMPLE, 32'hffff_ffff);
        end
        send_item(CMD_SAMPLE, 32'h1234_5678);      // idle sample after the tail
        send_item(CMD_END, 32'h0);                 // end after the message
        drain();

        // random sets: receiver sparse then sender sparse, then no gaps
        run_setting(BITS_ONE, 3'd2, 32'hffff_ffff, 33, 80);
        run_setting(BITS_TWO, 3'd1, 32'd60, 33, 80);
        run_setting(BITS_FOUR, 3'd4, 32'd0, 80, 33);
        run_setting(BITS_SPARE, 3'd3, 32'd200, 80, 33);
        hold_request = 1'b1;
        run_setting(BITS_FOUR, 3'd0, 32'd1000, 0, 0);
        run_setting(BITS_TWO, 3'd7, 32'h8000_0000, 0, 0);
        run_setting(BITS_ONE, 3'd5, 32'd25, 0, 0);

        if (fail_count == 0)
            $display("lsb_text_embedder test passed");
        else
            $display("lsb_text_embedder test failed");
        $finish;
    end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/lte_pkg.sv
hw/rtl/lte_in_if.sv
hw/rtl/lte_out_if.sv
hw/rtl/lte_front.sv
hw/rtl/lte_queue.sv
hw/rtl/lte_back.sv
hw/rtl/lsb_text_embedder.sv
tb/lte_embed_checker.sv
tb/tb_lsb_text_embedder.sv
